// File: hdl/thpd_pkg.sv
// ----------------------------------------------------------------------------
// Timed H-bridge pump driver package
// Shared types, codes and sizes for the pump driver controller and datapath.
// ----------------------------------------------------------------------------
package thpd_pkg;

   // Pump slots carried on the ports, and the default number of live pumps
   localparam int SLOT_COUNT         = 4;
   localparam int PUMP_COUNT_DEFAULT = 4;

   localparam int DUTY_WIDTH  = 8;
   localparam int TIME_WIDTH  = 32;
   localparam int INDEX_WIDTH = 3;
   localparam int SEL_WIDTH   = 2;
   localparam int CSR_IDX_WIDTH = 2;

   // Operation codes
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_STOP  = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   // Drive modes
   localparam logic [1:0] DRV_FORWARD = 2'd0;
   localparam logic [1:0] DRV_REVERSE = 2'd1;
   localparam logic [1:0] DRV_BRAKE   = 2'd2;
   localparam logic [1:0] DRV_COAST   = 2'd3;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
   } ctl_cmd_type;

   // Input beat
   typedef struct packed {
      logic [1:0]             func;
      logic [INDEX_WIDTH-1:0] pump_index;
      logic [TIME_WIDTH-1:0]  duration_ms;
      logic [1:0]             direction;
      logic                   brake;
   } req_type;

   // Result beat
   typedef struct packed {
      logic                  accepted;
      logic [SLOT_COUNT-1:0] running_mask;
      logic [DUTY_WIDTH-1:0] pump0_a_level;
      logic [DUTY_WIDTH-1:0] pump0_b_level;
      logic [DUTY_WIDTH-1:0] pump1_a_level;
      logic [DUTY_WIDTH-1:0] pump1_b_level;
      logic [DUTY_WIDTH-1:0] pump2_a_level;
      logic [DUTY_WIDTH-1:0] pump2_b_level;
      logic [DUTY_WIDTH-1:0] pump3_a_level;
      logic [DUTY_WIDTH-1:0] pump3_b_level;
   } rsp_type;

endpackage

// File: hdl/thpd_ctrl.sv
// ----------------------------------------------------------------------------
// Pump driver controller
// Sequences capture and execution of one beat and owns the result valid flag.
// ----------------------------------------------------------------------------
module thpd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output thpd_pkg::ctl_cmd_type  cmd
);

   thpd_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // State and valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= thpd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.exec = 1'b0;
      case (state_ff)
         thpd_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = thpd_pkg::ST_EXEC;
            end
         end
         thpd_pkg::ST_EXEC: begin
            // execute only once the result register is free or draining
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.exec = 1'b1;
               state_in = thpd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = thpd_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold the result until taken
   always_comb begin
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = (state_ff != thpd_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Every executed beat shows up as a result
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("executed beat did not raise result valid");

   // A captured beat is always executed before the next capture
   a_load_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == thpd_pkg::ST_EXEC) && !cmd.load)
      else $error("captured beat not held for execution");

endmodule

// File: hdl/thpd_datapath.sv
// ----------------------------------------------------------------------------
// Pump driver datapath
// Holds duty registers, per-pump run state and the result register; applies
// start, stop and tick beats on command.
// ----------------------------------------------------------------------------
module thpd_datapath #(
   parameter int PUMP_COUNT = thpd_pkg::PUMP_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  thpd_pkg::ctl_cmd_type                cmd,
   input  thpd_pkg::req_type                    req_data,
   input  logic                                 csr_we,
   input  logic [thpd_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [thpd_pkg::DUTY_WIDTH-1:0]      csr_wdata,
   output thpd_pkg::rsp_type                    rsp_data
);

   localparam int SLOTS = thpd_pkg::SLOT_COUNT;
   localparam int DW    = thpd_pkg::DUTY_WIDTH;
   localparam int TW    = thpd_pkg::TIME_WIDTH;
   localparam logic [thpd_pkg::INDEX_WIDTH-1:0] PUMP_LIMIT =
      thpd_pkg::INDEX_WIDTH'(PUMP_COUNT);
   localparam logic [TW-1:0] TIME_MAX = '1;

   thpd_pkg::req_type item_ff;
   thpd_pkg::rsp_type out_ff, out_in;

   logic [DW-1:0]    duty_ff     [SLOTS];
   logic [SLOTS-1:0] run_ff, run_in;
   logic [TW-1:0]    elapsed_ff  [SLOTS];
   logic [TW-1:0]    elapsed_in  [SLOTS];
   logic [TW-1:0]    length_ff   [SLOTS];
   logic [TW-1:0]    length_in   [SLOTS];
   logic [DW-1:0]    level_a_ff  [SLOTS];
   logic [DW-1:0]    level_a_in  [SLOTS];
   logic [DW-1:0]    level_b_ff  [SLOTS];
   logic [DW-1:0]    level_b_in  [SLOTS];

   logic [thpd_pkg::SEL_WIDTH-1:0] sel;
   logic                           index_ok;
   logic                           accepted;
   logic [TW-1:0]                  bumped [SLOTS];
   logic [SLOTS-1:0]               live_mask;
   logic [DW-1:0]                  out_a [SLOTS];
   logic [DW-1:0]                  out_b [SLOTS];

   // Channel levels for a drive mode
   function automatic logic [2*DW-1:0] drive_levels(input logic [1:0] mode,
                                                    input logic [DW-1:0] duty);
      logic [2*DW-1:0] lv;
      case (mode)
         thpd_pkg::DRV_FORWARD: lv = {duty, {DW{1'b0}}};
         thpd_pkg::DRV_REVERSE: lv = {{DW{1'b0}}, duty};
         thpd_pkg::DRV_BRAKE:   lv = {duty, duty};
         default:               lv = '0;
      endcase
      return lv;
   endfunction

   // Capture the input beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
   end

   // Duty registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            duty_ff[i] <= '1;
         end
      end else if (csr_we) begin
         duty_ff[csr_index] <= csr_wdata;
      end
   end

   assign sel      = item_ff.pump_index[thpd_pkg::SEL_WIDTH-1:0];
   assign index_ok = (item_ff.pump_index < PUMP_LIMIT);

   // Saturating elapsed count per pump
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         bumped[i] = (elapsed_ff[i] == TIME_MAX) ? elapsed_ff[i] : elapsed_ff[i] + 1'b1;
         live_mask[i] = (i < PUMP_COUNT);
      end
   end

   // Apply the beat to the pump state
   always_comb begin
      run_in   = run_ff;
      accepted = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         elapsed_in[i] = elapsed_ff[i];
         length_in[i]  = length_ff[i];
         level_a_in[i] = level_a_ff[i];
         level_b_in[i] = level_b_ff[i];
      end
      case (item_ff.func)
         thpd_pkg::FUNC_START: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (index_ok && sel == thpd_pkg::SEL_WIDTH'(i) && !run_ff[i]) begin
                  run_in[i]     = 1'b1;
                  elapsed_in[i] = '0;
                  length_in[i]  = item_ff.duration_ms;
                  {level_a_in[i], level_b_in[i]} =
                     drive_levels(item_ff.direction, duty_ff[i]);
                  accepted      = 1'b1;
               end
            end
         end
         thpd_pkg::FUNC_STOP: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (index_ok && sel == thpd_pkg::SEL_WIDTH'(i)) begin
                  run_in[i] = 1'b0;
                  {level_a_in[i], level_b_in[i]} = drive_levels(
                     item_ff.brake ? thpd_pkg::DRV_BRAKE : thpd_pkg::DRV_COAST,
                     duty_ff[i]);
               end
            end
            accepted = index_ok;
         end
         thpd_pkg::FUNC_TICK: begin
            // advance running pumps and coast those whose time is up
            for (int i = 0; i < SLOTS; i++) begin
               if (live_mask[i] && run_ff[i]) begin
                  elapsed_in[i] = bumped[i];
                  if (bumped[i] >= length_ff[i]) begin
                     run_in[i]     = 1'b0;
                     level_a_in[i] = '0;
                     level_b_in[i] = '0;
                  end
               end
            end
            accepted = 1'b1;
         end
         default: begin
            accepted = 1'b0;
         end
      endcase
   end

   // Result from the updated state
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         out_a[i] = live_mask[i] ? level_a_in[i] : '0;
         out_b[i] = live_mask[i] ? level_b_in[i] : '0;
      end
      out_in.accepted      = accepted;
      out_in.running_mask  = run_in & live_mask;
      out_in.pump0_a_level = out_a[0];
      out_in.pump0_b_level = out_b[0];
      out_in.pump1_a_level = out_a[1];
      out_in.pump1_b_level = out_b[1];
      out_in.pump2_a_level = out_a[2];
      out_in.pump2_b_level = out_b[2];
      out_in.pump3_a_level = out_a[3];
      out_in.pump3_b_level = out_b[3];
   end

   // Pump state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            elapsed_ff[i] <= '0;
            length_ff[i]  <= '0;
            level_a_ff[i] <= '0;
            level_b_ff[i] <= '0;
         end
      end else if (cmd.exec) begin
         run_ff <= run_in & live_mask;
         for (int i = 0; i < SLOTS; i++) begin
            elapsed_ff[i] <= elapsed_in[i];
            length_ff[i]  <= length_in[i];
            level_a_ff[i] <= level_a_in[i];
            level_b_ff[i] <= level_b_in[i];
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         out_ff <= out_in;
      end
   end

   assign rsp_data = out_ff;

   // Pumps beyond the live count never run
   a_no_dead_pumps: assert property (@(posedge clock) disable iff (reset)
      (run_ff & ~live_mask) == '0)
      else $error("pump outside the live count marked running");

   // A tick beat always reports accepted
   a_tick_accepted: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && item_ff.func == thpd_pkg::FUNC_TICK |=> out_ff.accepted)
      else $error("tick beat not reported as accepted");

endmodule

// File: hdl/timed_hbridge_pump_driver_unit.sv
// Timed H-bridge pump driver. Each beat is first captured into the input
// register, then applied to the pump state while loading the result
// register; no new beat is taken until the last one has been applied. A new
// beat is captured while an earlier result still waits in the result
// register; execution of that beat holds until the register is taken. Tick
// beats update all pumps in parallel in the execute cycle. Duty registers are
// to be written through the csr port while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
// Timed H-bridge pump driver top level
// Joins the controller and datapath and exposes the beat and csr ports.
// ----------------------------------------------------------------------------
module timed_hbridge_pump_driver_unit #(
   parameter int PUMP_COUNT = thpd_pkg::PUMP_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  thpd_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output thpd_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [thpd_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [thpd_pkg::DUTY_WIDTH-1:0]      csr_wdata
);

   thpd_pkg::ctl_cmd_type cmd;

   // Sequencing
   thpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Pump state and result
   thpd_datapath #(
      .PUMP_COUNT (PUMP_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/timed_hbridge_pump_driver_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timed H-bridge pump driver testbench
// Sends start, stop, tick and spare op code beats through the request channel
// with random gaps and random result stalls. A local pump model predicts every
// status beat, and each returned beat is compared with it field by field. The
// duty registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module timed_hbridge_pump_driver_unit_tb;

   localparam int PUMPS = thpd_pkg::PUMP_COUNT_DEFAULT;
   localparam logic [1:0] FUNC_SPARE = 2'd3;     // unused op code, ignored
   localparam int PHASES = 6;
   localparam int BEATS_PER_PHASE = 320;
   localparam int MAX_REPORTS = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   thpd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   thpd_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [thpd_pkg::CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [thpd_pkg::DUTY_WIDTH-1:0] csr_wdata = '0;

   thpd_pkg::req_type cmd_backlog[$];
   thpd_pkg::rsp_type status_due[$];
   int unsigned mismatches = 0;
   logic steady_flow = 1'b0;
   int unsigned send_gap = 0;
   int unsigned take_gap = 0;

   // Local copy of the pump state and duty registers
   logic [thpd_pkg::DUTY_WIDTH-1:0] duty_reg [thpd_pkg::SLOT_COUNT];
   logic                            running  [thpd_pkg::SLOT_COUNT];
   logic [thpd_pkg::TIME_WIDTH-1:0] elapsed  [thpd_pkg::SLOT_COUNT];
   logic [thpd_pkg::TIME_WIDTH-1:0] run_len  [thpd_pkg::SLOT_COUNT];
   logic [thpd_pkg::DUTY_WIDTH-1:0] chan_a   [thpd_pkg::SLOT_COUNT];
   logic [thpd_pkg::DUTY_WIDTH-1:0] chan_b   [thpd_pkg::SLOT_COUNT];

   timed_hbridge_pump_driver_unit #(
      .PUMP_COUNT(PUMPS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Pick the idle cycles before the next beat on either side
   function automatic int unsigned draw_gap();
      if (steady_flow || $urandom_range(0, 4) == 0)
         return 0;
      return $urandom_range(0, 11);
   endfunction

   // Set both bridge channels of one pump for a drive mode
   function automatic void set_drive(int p, logic [1:0] mode,
                                     logic [thpd_pkg::DUTY_WIDTH-1:0] level);
      case (mode)
         thpd_pkg::DRV_FORWARD: begin
            chan_a[p] = level;
            chan_b[p] = '0;
         end
         thpd_pkg::DRV_REVERSE: begin
            chan_a[p] = '0;
            chan_b[p] = level;
         end
         thpd_pkg::DRV_BRAKE: begin
            chan_a[p] = level;
            chan_b[p] = level;
         end
         default: begin
            chan_a[p] = '0;
            chan_b[p] = '0;
         end
      endcase
   endfunction

   // Apply one command to the pump state and return the status beat it yields
   function automatic thpd_pkg::rsp_type next_pump_status(thpd_pkg::req_type cmd);
      thpd_pkg::rsp_type st;
      logic ok;
      int p;
      ok = 1'b0;
      p = int'(cmd.pump_index);
      case (cmd.func)
         thpd_pkg::FUNC_START: begin
            if (p < PUMPS) begin
               if (!running[p]) begin
                  running[p] = 1'b1;
                  elapsed[p] = '0;
                  run_len[p] = cmd.duration_ms;
                  set_drive(p, cmd.direction, duty_reg[p]);
                  ok = 1'b1;
               end
            end
         end
         thpd_pkg::FUNC_STOP: begin
            if (p < PUMPS) begin
               if (cmd.brake)
                  set_drive(p, thpd_pkg::DRV_BRAKE, duty_reg[p]);
               else
                  set_drive(p, thpd_pkg::DRV_COAST, '0);
               running[p] = 1'b0;
               ok = 1'b1;
            end
         end
         thpd_pkg::FUNC_TICK: begin
            // advance every running pump, saturate, coast the ones that are due
            for (int i = 0; i < PUMPS; i++) begin
               if (running[i]) begin
                  if (elapsed[i] != '1)
                     elapsed[i] = elapsed[i] + 1'b1;
                  if (elapsed[i] >= run_len[i]) begin
                     set_drive(i, thpd_pkg::DRV_COAST, '0);
                     running[i] = 1'b0;
                  end
               end
            end
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      st = '0;
      st.accepted = ok;
      for (int i = 0; i < PUMPS; i++)
         st.running_mask[i] = running[i];
      st.pump0_a_level = chan_a[0];
      st.pump0_b_level = chan_b[0];
      st.pump1_a_level = chan_a[1];
      st.pump1_b_level = chan_b[1];
      st.pump2_a_level = chan_a[2];
      st.pump2_b_level = chan_b[2];
      st.pump3_a_level = chan_a[3];
      st.pump3_b_level = chan_b[3];
      return st;
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   task automatic check_status(thpd_pkg::rsp_type got, thpd_pkg::rsp_type want);
      check_field("accepted", 32'(got.accepted), 32'(want.accepted));
      check_field("running_mask", 32'(got.running_mask), 32'(want.running_mask));
      check_field("pump0_a_level", 32'(got.pump0_a_level), 32'(want.pump0_a_level));
      check_field("pump0_b_level", 32'(got.pump0_b_level), 32'(want.pump0_b_level));
      check_field("pump1_a_level", 32'(got.pump1_a_level), 32'(want.pump1_a_level));
      check_field("pump1_b_level", 32'(got.pump1_b_level), 32'(want.pump1_b_level));
      check_field("pump2_a_level", 32'(got.pump2_a_level), 32'(want.pump2_a_level));
      check_field("pump2_b_level", 32'(got.pump2_b_level), 32'(want.pump2_b_level));
      check_field("pump3_a_level", 32'(got.pump3_a_level), 32'(want.pump3_a_level));
      check_field("pump3_b_level", 32'(got.pump3_b_level), 32'(want.pump3_b_level));
   endtask

   task automatic push_cmd(logic [1:0] func, logic [thpd_pkg::INDEX_WIDTH-1:0] idx,
                           logic [thpd_pkg::TIME_WIDTH-1:0] dur, logic [1:0] dir,
                           logic brk);
      thpd_pkg::req_type cmd;
      cmd.func = func;
      cmd.pump_index = idx;
      cmd.duration_ms = dur;
      cmd.direction = dir;
      cmd.brake = brk;
      cmd_backlog.push_back(cmd);
   endtask

   // Hold until every command is sent and every status beat has come back
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (cmd_backlog.size() != 0 || req_valid || status_due.size() != 0);
   endtask

   // Request side: send beats from the backlog, predict each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= draw_gap();
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            status_due.push_back(next_pump_status(req_data));
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (cmd_backlog.size() != 0) begin
            req_data <= cmd_backlog.pop_front();
            req_valid <= 1'b1;
            send_gap <= draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: check each taken beat, then stall for a random stretch
   always @(posedge clock) begin : take_side
      int unsigned hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         take_gap <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (status_due.size() == 0)
            report_mismatch("status beat with no command pending");
         else
            check_status(rsp_data, status_due.pop_front());
         hold = draw_gap();
         take_gap <= hold;
         rsp_stall <= (hold != 0);
      end else if (take_gap != 0) begin
         take_gap <= take_gap - 1;
         rsp_stall <= (take_gap > 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      thpd_pkg::req_type cmd;
      int unsigned r;
      logic [thpd_pkg::DUTY_WIDTH-1:0] v;

      for (int i = 0; i < thpd_pkg::SLOT_COUNT; i++) begin
         duty_reg[i] = 8'd255;
         running[i] = 1'b0;
         elapsed[i] = '0;
         run_len[i] = '0;
         chan_a[i] = '0;
         chan_b[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at the reset duty
      push_cmd(thpd_pkg::FUNC_TICK, 3'd0, 32'd0, thpd_pkg::DRV_FORWARD, 1'b0);
      push_cmd(thpd_pkg::FUNC_START, 3'd0, 32'd3, thpd_pkg::DRV_FORWARD, 1'b0);
      push_cmd(thpd_pkg::FUNC_START, 3'd1, 32'd0, thpd_pkg::DRV_REVERSE, 1'b0);
      push_cmd(thpd_pkg::FUNC_START, 3'd2, 32'd1, thpd_pkg::DRV_BRAKE, 1'b1);
      push_cmd(thpd_pkg::FUNC_START, 3'd3, 32'hFFFF_FFFF, thpd_pkg::DRV_COAST, 1'b0);
      // start while running is refused
      push_cmd(thpd_pkg::FUNC_START, 3'd0, 32'd5, thpd_pkg::DRV_REVERSE, 1'b0);
      // invalid indexes and the spare op code do nothing
      push_cmd(thpd_pkg::FUNC_START, 3'd4, 32'd2, thpd_pkg::DRV_FORWARD, 1'b0);
      push_cmd(thpd_pkg::FUNC_STOP, 3'd7, 32'd0, thpd_pkg::DRV_FORWARD, 1'b1);
      push_cmd(FUNC_SPARE, 3'd0, 32'd9, thpd_pkg::DRV_BRAKE, 1'b1);
      // zero and one length runs end on the first tick, three on the third
      push_cmd(thpd_pkg::FUNC_TICK, 3'd7, 32'hFFFF_FFFF, thpd_pkg::DRV_COAST, 1'b1);
      push_cmd(thpd_pkg::FUNC_TICK, 3'd0, 32'd0, thpd_pkg::DRV_FORWARD, 1'b0);
      push_cmd(thpd_pkg::FUNC_TICK, 3'd0, 32'd0, thpd_pkg::DRV_FORWARD, 1'b0);
      push_cmd(thpd_pkg::FUNC_STOP, 3'd3, 32'd0, thpd_pkg::DRV_FORWARD, 1'b1);
      // stop while idle still sets the drive
      push_cmd(thpd_pkg::FUNC_STOP, 3'd3, 32'd0, thpd_pkg::DRV_FORWARD, 1'b0);
      push_cmd(thpd_pkg::FUNC_STOP, 3'd2, 32'd0, thpd_pkg::DRV_FORWARD, 1'b1);
      push_cmd(thpd_pkg::FUNC_START, 3'd1, 32'd0, thpd_pkg::DRV_FORWARD, 1'b0);
      push_cmd(thpd_pkg::FUNC_TICK, 3'd0, 32'd0, thpd_pkg::DRV_FORWARD, 1'b0);
      push_cmd(thpd_pkg::FUNC_START, 3'd0, 32'd2, thpd_pkg::DRV_BRAKE, 1'b0);
      push_cmd(thpd_pkg::FUNC_STOP, 3'd0, 32'd0, thpd_pkg::DRV_REVERSE, 1'b0);
      push_cmd(thpd_pkg::FUNC_START, 3'd5, 32'hFFFF_FFFF, thpd_pkg::DRV_COAST, 1'b1);
      push_cmd(thpd_pkg::FUNC_START, 3'd3, 32'd1, thpd_pkg::DRV_FORWARD, 1'b0);
      push_cmd(thpd_pkg::FUNC_TICK, 3'd0, 32'd0, thpd_pkg::DRV_FORWARD, 1'b0);
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         // Rewrite all duty registers while idle
         repeat (4) @(posedge clock);
         for (int i = 0; i < thpd_pkg::SLOT_COUNT; i++) begin
            case (ph)
               0: v = 8'h00;
               1: v = 8'hFF;
               3: v = (i[0]) ? 8'h7F : 8'h80;
               default: v = 8'($urandom_range(0, 255));
            endcase
            @(posedge clock);
            csr_we <= 1'b1;
            csr_index <= i[thpd_pkg::CSR_IDX_WIDTH-1:0];
            csr_wdata <= v;
            duty_reg[i] = v;
         end
         @(posedge clock);
         csr_we <= 1'b0;

         // Mostly ticks, starts and stops on live pumps with short runs
         steady_flow = (ph == 2);
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
               cmd.func = thpd_pkg::FUNC_TICK;
            else if (r < 75)
               cmd.func = thpd_pkg::FUNC_START;
            else if (r < 95)
               cmd.func = thpd_pkg::FUNC_STOP;
            else
               cmd.func = FUNC_SPARE;
            if ($urandom_range(0, 9) == 0)
               cmd.pump_index = 3'($urandom_range(4, 7));
            else
               cmd.pump_index = 3'($urandom_range(0, PUMPS - 1));
            if ($urandom_range(0, 15) == 0)
               cmd.duration_ms = $urandom();
            else
               cmd.duration_ms = $urandom_range(0, 12);
            cmd.direction = 2'($urandom_range(0, 3));
            cmd.brake = 1'($urandom_range(0, 1));
            cmd_backlog.push_back(cmd);
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Stop a hung run
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
